@@ hdl/kpi_pkg.sv @@
// Shared constants, types and helper functions of the keyframe pose interpolator.
package kpi_pkg;

    // Storage geometry
    localparam int MOTIONS    = 8;
    localparam int KEYS       = 8;
    localparam int PARTS      = 16;
    localparam int FRAME_BITS = 12;
    localparam int CHANNELS   = 6;
    localparam int POS_CH     = 3;
    localparam int MAX_OUT    = 16;
    localparam int NP_MAX     = (PARTS < MAX_OUT) ? PARTS : MAX_OUT;

    localparam int MOT_W  = (MOTIONS > 1) ? $clog2(MOTIONS) : 1;
    localparam int KEY_W  = $clog2(KEYS);
    localparam int PART_W = (PARTS > 1) ? $clog2(PARTS) : 1;
    localparam int CH_W   = $clog2(CHANNELS);
    localparam int FW     = FRAME_BITS;

    // Datapath widths: difference, product and value
    localparam int DW = (FRAME_BITS + 20 > 34) ? FRAME_BITS + 20 : 34;
    localparam int PW = DW + FW + 1;
    localparam int VW = PW;
    localparam int DCNT_W = $clog2(PW);

    // Memory depths
    localparam int KS_DEPTH = MOTIONS * KEYS * PARTS * CHANNELS;
    localparam int FR_DEPTH = MOTIONS * KEYS;
    localparam int OF_DEPTH = PARTS * CHANNELS;
    localparam int KS_AW    = $clog2(KS_DEPTH);
    localparam int FR_AW    = $clog2(FR_DEPTH);
    localparam int OF_AW    = $clog2(OF_DEPTH);

    typedef logic signed [VW-1:0] t_val;
    typedef logic signed [DW-1:0] t_diff;
    typedef logic signed [PW-1:0] t_prod;
    typedef logic [PW-1:0]        t_mag;
    typedef logic [FW-1:0]        t_frm;
    typedef logic [FW:0]          t_frm_x;
    typedef logic [DCNT_W-1:0]    t_dcnt;
    typedef logic [MOT_W-1:0]     t_mot;
    typedef logic [KEY_W-1:0]     t_key;
    typedef logic [KEY_W:0]       t_nkey;
    typedef logic [PART_W-1:0]    t_part;
    typedef logic [PART_W:0]      t_npart;
    typedef logic [CH_W-1:0]      t_ch;
    typedef logic [KS_AW-1:0]     t_ks_addr;
    typedef logic [FR_AW-1:0]     t_fr_addr;
    typedef logic [OF_AW-1:0]     t_of_addr;

    // Request codes
    localparam logic [2:0] REQ_KEY_VAL = 3'd0;
    localparam logic [2:0] REQ_KEY_FRM = 3'd1;
    localparam logic [2:0] REQ_OFFSET  = 3'd2;
    localparam logic [2:0] REQ_START   = 3'd3;
    localparam logic [2:0] REQ_TICK    = 3'd4;

    // Configuration register indexes
    localparam logic [0:0] CFG_KEYS  = 1'd0;
    localparam logic [0:0] CFG_PARTS = 1'd1;

    // Interpolation unit request and response
    typedef struct packed {
        logic go;
        t_val a;
        t_val b;
        t_frm num;
        t_frm den;
    } t_lerp_req;

    typedef struct packed {
        logic done;
        t_val res;
    } t_lerp_rsp;

    function automatic t_ks_addr ks_addr(int unsigned m, int unsigned k,
                                         int unsigned p, int unsigned ch);
        return t_ks_addr'(((m * KEYS + k) * PARTS + p) * CHANNELS + ch);
    endfunction

    function automatic t_fr_addr fr_addr(int unsigned m, int unsigned k);
        return t_fr_addr'(m * KEYS + k);
    endfunction

    function automatic t_of_addr of_addr(int unsigned p, int unsigned ch);
        return t_of_addr'(p * CHANNELS + ch);
    endfunction

    // Sign-extend a stored word: full word for positions, low half for angles
    function automatic t_val ext_chan(logic [31:0] u, logic ang);
        t_val r;
        if (ang) begin
            r = t_val'($signed(u[15:0]));
        end else begin
            r = t_val'($signed(u));
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(t_val v);
        logic signed [31:0] r;
        r = v[31:0];
        if (!v[VW-1] && (|v[VW-2:31])) begin
            r = 32'sh7FFF_FFFF;
        end else if (v[VW-1] && !(&v[VW-2:31])) begin
            r = 32'sh8000_0000;
        end
        return r;
    endfunction

    // Next key, wrapped to the number of keys in use
    function automatic t_key key_next(t_key k, t_nkey n);
        t_nkey x;
        x = t_nkey'(k) + t_nkey'(1);
        for (int i = 0; i < KEYS; i++) begin
            if (x >= n) begin
                x = x - n;
            end
        end
        return t_key'(x);
    endfunction

endpackage

@@ hdl/kpi_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module kpi_ram #(
    parameter int W = 32,
    parameter int D = 64
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/kpi_lerp.sv @@
// Multi-cycle linear interpolation unit: a + (b - a) * num / den, truncated toward zero.
module kpi_lerp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kpi_pkg::t_lerp_req  i_req,
    output kpi_pkg::t_lerp_rsp  o_rsp
);

    typedef enum logic [4:0] {
        L_IDLE = 5'b00001,
        L_MUL  = 5'b00010,
        L_ABS  = 5'b00100,
        L_DIV  = 5'b01000,
        L_FIN  = 5'b10000
    } t_lstate;

    t_lstate r_state, n_state;

    kpi_pkg::t_val  r_a;
    kpi_pkg::t_diff r_diff;
    kpi_pkg::t_frm  r_num;
    kpi_pkg::t_frm  r_den;
    kpi_pkg::t_prod r_prod;
    kpi_pkg::t_mag  r_mag;
    kpi_pkg::t_frm  r_rem;
    logic           r_neg;
    kpi_pkg::t_dcnt r_cnt;

    kpi_pkg::t_frm_x rem_sh;
    logic            rem_ge;
    kpi_pkg::t_frm   rem_nx;
    kpi_pkg::t_prod  quo;

    // One restoring division step
    always_comb begin
        rem_sh = {r_rem, r_mag[kpi_pkg::PW-1]};
        rem_ge = (rem_sh >= {1'b0, r_den});
        rem_nx = rem_ge ? kpi_pkg::t_frm'(rem_sh - {1'b0, r_den})
                        : kpi_pkg::t_frm'(rem_sh);
        quo    = kpi_pkg::t_prod'(r_mag);
    end

    // Sequence multiply, magnitude, divide, finish
    always_comb begin
        n_state = r_state;
        case (r_state)
            L_IDLE: begin
                if (i_req.go) begin
                    n_state = L_MUL;
                end
            end
            L_MUL: n_state = L_ABS;
            L_ABS: n_state = L_DIV;
            L_DIV: begin
                if (r_cnt == kpi_pkg::t_dcnt'(kpi_pkg::PW - 1)) begin
                    n_state = L_FIN;
                end
            end
            L_FIN: n_state = L_IDLE;
            default: n_state = L_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            L_IDLE: begin
                r_a    <= i_req.a;
                r_diff <= kpi_pkg::t_diff'(i_req.b - i_req.a);
                r_num  <= i_req.num;
                r_den  <= i_req.den;
            end
            L_MUL: begin
                r_prod <= kpi_pkg::t_prod'(r_diff * $signed({1'b0, r_num}));
            end
            L_ABS: begin
                r_neg <= r_prod[kpi_pkg::PW-1];
                r_mag <= r_prod[kpi_pkg::PW-1] ? kpi_pkg::t_mag'(-r_prod)
                                               : kpi_pkg::t_mag'(r_prod);
                r_rem <= '0;
                r_cnt <= '0;
            end
            L_DIV: begin
                r_rem <= rem_nx;
                r_mag <= {r_mag[kpi_pkg::PW-2:0], rem_ge};
                r_cnt <= r_cnt + kpi_pkg::t_dcnt'(1);
            end
            default: begin
            end
        endcase
    end

    assign o_rsp.done = (r_state == L_FIN);
    assign o_rsp.res  = r_neg ? (r_a - quo) : (r_a + quo);

endmodule

@@ hdl/keyframe_pose_interpolator.sv @@
// Keyframe pose interpolator: writes and starts are taken in the accept beat; a tick
// walks every part in use and all its channels, its length set by the bit-serial
// divider (one division per channel, or three while a crossfade runs).
// One result per part, one cycle each with o_valid; the receiver cannot stall.
// Synchronous active-low reset clears offsets (valid bits) and motion state;
// key values and key frame counts hold nothing until written.
module keyframe_pose_interpolator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_idx,
    input  logic [4:0]         i_cfg_data,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_req_type,
    input  logic [2:0]         i_motion_index,
    input  logic [2:0]         i_key_index,
    input  logic [3:0]         i_part_index,
    input  logic [2:0]         i_channel_index,
    input  logic signed [31:0] i_channel_value,
    input  logic [11:0]        i_frame_count,
    input  logic               i_blend_start,
    output logic               o_valid,
    output logic [3:0]         o_part_number,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_pos_z,
    output logic signed [15:0] o_angle_x,
    output logic signed [15:0] o_angle_y,
    output logic signed [15:0] o_angle_z,
    output logic               o_last_part
);

    typedef enum logic [17:0] {
        S_IDLE  = 18'h00001,
        S_FRM_C = 18'h00002,
        S_FRM_B = 18'h00004,
        S_SETUP = 18'h00008,
        S_RD_A  = 18'h00010,
        S_RD_B  = 18'h00020,
        S_L1    = 18'h00040,
        S_W1    = 18'h00080,
        S_RD_BA = 18'h00100,
        S_RD_BB = 18'h00200,
        S_L2    = 18'h00400,
        S_W2    = 18'h00800,
        S_L3    = 18'h01000,
        S_W3    = 18'h02000,
        S_OFS   = 18'h04000,
        S_OFS_D = 18'h08000,
        S_EMIT  = 18'h10000,
        S_ADV   = 18'h20000
    } t_state;

    t_state r_state;

    // Configuration and motion state
    logic [3:0]     r_keys_in_use;
    logic [4:0]     r_parts_in_use;
    kpi_pkg::t_mot  r_cur_motion;
    kpi_pkg::t_key  r_cur_key;
    kpi_pkg::t_frm  r_cur_cnt;
    logic           r_blending;
    kpi_pkg::t_mot  r_bl_motion;
    kpi_pkg::t_key  r_bl_key;
    kpi_pkg::t_frm  r_bl_cnt;
    kpi_pkg::t_frm  r_fade_cnt;
    kpi_pkg::t_frm  r_fade_len;
    logic [kpi_pkg::OF_DEPTH-1:0] r_ofs_vld;

    // Tick sequencing and datapath
    kpi_pkg::t_part r_part;
    kpi_pkg::t_ch   r_ch;
    kpi_pkg::t_frm  r_den_c;
    kpi_pkg::t_frm  r_den_b;
    kpi_pkg::t_val  r_a;
    kpi_pkg::t_val  r_v;
    kpi_pkg::t_val  r_w;
    logic           r_ofs_hit;
    logic signed [31:0] r_pos [3];
    logic signed [15:0] r_ang [3];
    logic           r_last;

    logic               accept;
    kpi_pkg::t_nkey     nk;
    kpi_pkg::t_npart    np;
    kpi_pkg::t_key      kn_c;
    kpi_pkg::t_key      kn_b;
    logic               is_ang;
    logic               part_last;

    logic               ks_we;
    kpi_pkg::t_ks_addr  ks_waddr;
    kpi_pkg::t_ks_addr  ks_raddr;
    logic [31:0]        ks_rdata;
    kpi_pkg::t_val      key_val;

    logic               fr_we;
    kpi_pkg::t_fr_addr  fr_waddr;
    kpi_pkg::t_fr_addr  fr_raddr;
    kpi_pkg::t_frm      fr_rdata;
    kpi_pkg::t_frm      fr_eff;

    logic               of_we;
    kpi_pkg::t_of_addr  of_waddr;
    kpi_pkg::t_of_addr  of_raddr;
    logic [31:0]        of_rdata;
    kpi_pkg::t_val      off_val;
    kpi_pkg::t_val      chan_sum;

    kpi_pkg::t_lerp_req lerp_req;
    kpi_pkg::t_lerp_rsp lerp_rsp;
    kpi_pkg::t_val      lerp_sat;

    kpi_pkg::t_frm      bl_cnt_inc;
    kpi_pkg::t_key      bl_key_nx;
    kpi_pkg::t_frm      bl_cnt_nx;
    kpi_pkg::t_frm      fade_inc;
    kpi_pkg::t_frm      cur_cnt_inc;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);

    // Clamp the registers to usable counts
    always_comb begin
        nk = kpi_pkg::t_nkey'(r_keys_in_use);
        if (r_keys_in_use == 4'd0) begin
            nk = kpi_pkg::t_nkey'(1);
        end else if (r_keys_in_use > kpi_pkg::KEYS) begin
            nk = kpi_pkg::t_nkey'(kpi_pkg::KEYS);
        end
        np = kpi_pkg::t_npart'(r_parts_in_use);
        if (r_parts_in_use == 5'd0) begin
            np = kpi_pkg::t_npart'(1);
        end else if (r_parts_in_use > kpi_pkg::NP_MAX) begin
            np = kpi_pkg::t_npart'(kpi_pkg::NP_MAX);
        end
    end

    assign kn_c      = kpi_pkg::key_next(r_cur_key, nk);
    assign kn_b      = kpi_pkg::key_next(r_bl_key, nk);
    assign is_ang    = (r_ch >= kpi_pkg::POS_CH);
    assign part_last = ((kpi_pkg::t_npart'(r_part) + kpi_pkg::t_npart'(1)) == np);

    // Store writes, taken in the accept beat
    always_comb begin
        ks_we = accept && (i_req_type == kpi_pkg::REQ_KEY_VAL)
                && (i_motion_index < kpi_pkg::MOTIONS) && (i_key_index < kpi_pkg::KEYS)
                && (i_part_index < kpi_pkg::PARTS)
                && (i_channel_index < kpi_pkg::CHANNELS);
        fr_we = accept && (i_req_type == kpi_pkg::REQ_KEY_FRM)
                && (i_motion_index < kpi_pkg::MOTIONS) && (i_key_index < kpi_pkg::KEYS);
        of_we = accept && (i_req_type == kpi_pkg::REQ_OFFSET)
                && (i_part_index < kpi_pkg::PARTS)
                && (i_channel_index < kpi_pkg::CHANNELS);
        ks_waddr = kpi_pkg::ks_addr(i_motion_index, i_key_index, i_part_index,
                                    i_channel_index);
        fr_waddr = kpi_pkg::fr_addr(i_motion_index, i_key_index);
        of_waddr = kpi_pkg::of_addr(i_part_index, i_channel_index);
    end

    // Read address selection by state
    always_comb begin
        case (r_state)
            S_RD_B:  ks_raddr = kpi_pkg::ks_addr(r_cur_motion, kn_c, r_part, r_ch);
            S_RD_BA: ks_raddr = kpi_pkg::ks_addr(r_bl_motion, r_bl_key, r_part, r_ch);
            S_RD_BB: ks_raddr = kpi_pkg::ks_addr(r_bl_motion, kn_b, r_part, r_ch);
            default: ks_raddr = kpi_pkg::ks_addr(r_cur_motion, r_cur_key, r_part, r_ch);
        endcase
        if (r_state == S_FRM_B) begin
            fr_raddr = kpi_pkg::fr_addr(r_bl_motion, r_bl_key);
        end else begin
            fr_raddr = kpi_pkg::fr_addr(r_cur_motion, r_cur_key);
        end
        of_raddr = kpi_pkg::of_addr(r_part, r_ch);
    end

    kpi_ram #(.W(32), .D(kpi_pkg::KS_DEPTH)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (ks_we),
        .i_waddr (ks_waddr),
        .i_wdata (i_channel_value),
        .i_raddr (ks_raddr),
        .o_rdata (ks_rdata)
    );

    kpi_ram #(.W(kpi_pkg::FW), .D(kpi_pkg::FR_DEPTH)) u_frm_ram (
        .i_clk   (i_clk),
        .i_we    (fr_we),
        .i_waddr (fr_waddr),
        .i_wdata (kpi_pkg::t_frm'(i_frame_count)),
        .i_raddr (fr_raddr),
        .o_rdata (fr_rdata)
    );

    kpi_ram #(.W(32), .D(kpi_pkg::OF_DEPTH)) u_ofs_ram (
        .i_clk   (i_clk),
        .i_we    (of_we),
        .i_waddr (of_waddr),
        .i_wdata (i_channel_value),
        .i_raddr (of_raddr),
        .o_rdata (of_rdata)
    );

    assign key_val = kpi_pkg::ext_chan(ks_rdata, is_ang);
    assign fr_eff  = (fr_rdata == '0) ? kpi_pkg::t_frm'(1) : fr_rdata;
    assign off_val = r_ofs_hit ? kpi_pkg::ext_chan(of_rdata, is_ang) : '0;
    assign chan_sum = r_v + off_val;

    // Interpolation requests: current motion, target motion, crossfade
    always_comb begin
        lerp_req.go = (r_state == S_L1) || (r_state == S_L2) || (r_state == S_L3);
        case (r_state)
            S_L2: begin
                lerp_req.a   = r_a;
                lerp_req.b   = key_val;
                lerp_req.num = r_bl_cnt;
                lerp_req.den = r_den_b;
            end
            S_L3: begin
                lerp_req.a   = r_v;
                lerp_req.b   = r_w;
                lerp_req.num = r_fade_cnt;
                lerp_req.den = r_fade_len;
            end
            default: begin
                lerp_req.a   = r_a;
                lerp_req.b   = key_val;
                lerp_req.num = r_cur_cnt;
                lerp_req.den = r_den_c;
            end
        endcase
    end

    kpi_lerp u_lerp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (lerp_req),
        .o_rsp   (lerp_rsp)
    );

    // Saturate positions per motion, leave angles unwrapped
    assign lerp_sat = is_ang ? lerp_rsp.res : kpi_pkg::t_val'(kpi_pkg::sat32(lerp_rsp.res));

    // Counter advance at the end of a tick
    always_comb begin
        bl_cnt_inc  = r_bl_cnt + kpi_pkg::t_frm'(1);
        bl_key_nx   = r_bl_key;
        bl_cnt_nx   = bl_cnt_inc;
        if (bl_cnt_inc >= r_den_b) begin
            bl_cnt_nx = '0;
            bl_key_nx = kn_b;
        end
        fade_inc    = r_fade_cnt + kpi_pkg::t_frm'(1);
        cur_cnt_inc = r_cur_cnt + kpi_pkg::t_frm'(1);
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_keys_in_use  <= 4'd2;
            r_parts_in_use <= 5'd2;
            r_cur_motion   <= '0;
            r_cur_key      <= '0;
            r_cur_cnt      <= '0;
            r_blending     <= 1'b0;
            r_bl_motion    <= '0;
            r_bl_key       <= '0;
            r_bl_cnt       <= '0;
            r_fade_cnt     <= '0;
            r_fade_len     <= kpi_pkg::t_frm'(1);
            r_ofs_vld      <= '0;
            r_part         <= '0;
            r_ch           <= '0;
        end else begin
            // register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    kpi_pkg::CFG_KEYS:  r_keys_in_use  <= i_cfg_data[3:0];
                    kpi_pkg::CFG_PARTS: r_parts_in_use <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (of_we) begin
                r_ofs_vld[of_waddr] <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (i_req_type)
                            kpi_pkg::REQ_START: begin
                                if (i_motion_index < kpi_pkg::MOTIONS) begin
                                    if (i_blend_start) begin
                                        r_blending  <= 1'b1;
                                        r_fade_len  <= (i_frame_count[kpi_pkg::FW-1:0] == '0)
                                                       ? kpi_pkg::t_frm'(1)
                                                       : kpi_pkg::t_frm'(i_frame_count);
                                        r_fade_cnt  <= '0;
                                        r_bl_motion <= kpi_pkg::t_mot'(i_motion_index);
                                        r_bl_key    <= '0;
                                        r_bl_cnt    <= '0;
                                    end else begin
                                        r_cur_motion <= kpi_pkg::t_mot'(i_motion_index);
                                        r_cur_key    <= '0;
                                        r_cur_cnt    <= '0;
                                    end
                                end
                            end
                            kpi_pkg::REQ_TICK: begin
                                r_state <= S_FRM_C;
                                r_part  <= '0;
                                r_ch    <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_FRM_C: r_state <= S_FRM_B;
                S_FRM_B: r_state <= S_SETUP;
                S_SETUP: r_state <= S_RD_A;
                S_RD_A:  r_state <= S_RD_B;
                S_RD_B:  r_state <= S_L1;
                S_L1:    r_state <= S_W1;
                S_W1: begin
                    if (lerp_rsp.done) begin
                        r_state <= r_blending ? S_RD_BA : S_OFS;
                    end
                end
                S_RD_BA: r_state <= S_RD_BB;
                S_RD_BB: r_state <= S_L2;
                S_L2:    r_state <= S_W2;
                S_W2: begin
                    if (lerp_rsp.done) begin
                        r_state <= S_L3;
                    end
                end
                S_L3:    r_state <= S_W3;
                S_W3: begin
                    if (lerp_rsp.done) begin
                        r_state <= S_OFS;
                    end
                end
                S_OFS:   r_state <= S_OFS_D;
                S_OFS_D: begin
                    if (r_ch == kpi_pkg::t_ch'(kpi_pkg::CHANNELS - 1)) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_ch    <= r_ch + kpi_pkg::t_ch'(1);
                        r_state <= S_RD_A;
                    end
                end
                S_EMIT: begin
                    r_ch <= '0;
                    if (part_last) begin
                        r_state <= S_ADV;
                    end else begin
                        r_part  <= r_part + kpi_pkg::t_part'(1);
                        r_state <= S_RD_A;
                    end
                end
                S_ADV: begin
                    // advance counters, hand over a finished fade
                    if (r_blending) begin
                        r_bl_cnt <= bl_cnt_nx;
                        r_bl_key <= bl_key_nx;
                        if (fade_inc >= r_fade_len) begin
                            r_fade_cnt   <= '0;
                            r_cur_motion <= r_bl_motion;
                            r_cur_cnt    <= bl_cnt_nx;
                            r_cur_key    <= bl_key_nx;
                            r_blending   <= 1'b0;
                        end else begin
                            r_fade_cnt <= fade_inc;
                        end
                    end else begin
                        if (cur_cnt_inc >= r_den_c) begin
                            r_cur_cnt <= '0;
                            r_cur_key <= kn_c;
                        end else begin
                            r_cur_cnt <= cur_cnt_inc;
                        end
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_FRM_B: r_den_c <= fr_eff;
            S_SETUP: r_den_b <= fr_eff;
            S_RD_B:  r_a     <= key_val;
            S_RD_BB: r_a     <= key_val;
            S_W1: begin
                if (lerp_rsp.done) begin
                    r_v <= lerp_sat;
                end
            end
            S_W2: begin
                if (lerp_rsp.done) begin
                    r_w <= lerp_sat;
                end
            end
            S_W3: begin
                if (lerp_rsp.done) begin
                    r_v <= lerp_rsp.res;
                end
            end
            S_OFS: r_ofs_hit <= r_ofs_vld[of_raddr];
            S_OFS_D: begin
                // add offset: saturate positions, wrap angles
                case (r_ch)
                    3'd0: r_pos[0] <= kpi_pkg::sat32(chan_sum);
                    3'd1: r_pos[1] <= kpi_pkg::sat32(chan_sum);
                    3'd2: r_pos[2] <= kpi_pkg::sat32(chan_sum);
                    3'd3: r_ang[0] <= chan_sum[15:0];
                    3'd4: r_ang[1] <= chan_sum[15:0];
                    3'd5: r_ang[2] <= chan_sum[15:0];
                    default: begin
                    end
                endcase
                r_last <= part_last;
            end
            default: begin
            end
        endcase
    end

    assign o_valid       = (r_state == S_EMIT);
    assign o_part_number = 4'(r_part);
    assign o_pos_x       = r_pos[0];
    assign o_pos_y       = r_pos[1];
    assign o_pos_z       = r_pos[2];
    assign o_angle_x     = r_ang[0];
    assign o_angle_y     = r_ang[1];
    assign o_angle_z     = r_ang[2];
    assign o_last_part   = r_last;

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench of the keyframe pose interpolator, predictor included.
`timescale 1ns / 100ps

module tb_top;

    localparam longint CYCLE_LIMIT = 2_000_000;
    localparam int     SETTLE      = 40;

    typedef struct {
        logic [2:0]  req;
        logic [2:0]  mot;
        logic [2:0]  key;
        logic [3:0]  part;
        logic [2:0]  ch;
        logic [31:0] val;
        logic [11:0] fc;
        logic        bl;
        logic        typ_px;
        logic [31:0] px;
        logic        typ_ax;
        logic [15:0] ax;
    } t_req_row;

    typedef struct {
        logic [3:0]  part;
        logic [31:0] px, py, pz;
        logic [15:0] ax, ay, az;
        logic        last;
    } t_pose;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_idx = '0;
    logic [4:0]  i_cfg_data = '0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  i_req_type = '0;
    logic [2:0]  i_motion_index = '0;
    logic [2:0]  i_key_index = '0;
    logic [3:0]  i_part_index = '0;
    logic [2:0]  i_channel_index = '0;
    logic signed [31:0] i_channel_value = '0;
    logic [11:0] i_frame_count = '0;
    logic        i_blend_start = 1'b0;
    logic        o_valid;
    logic [3:0]  o_part_number;
    logic signed [31:0] o_pos_x, o_pos_y, o_pos_z;
    logic signed [15:0] o_angle_x, o_angle_y, o_angle_z;
    logic        o_last_part;

    keyframe_pose_interpolator uut (.*);

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Model state of the pose engine
    logic [31:0] key_vals [kpi_pkg::KS_DEPTH];
    logic [11:0] key_durs [kpi_pkg::FR_DEPTH];
    logic [31:0] offsets  [kpi_pkg::OF_DEPTH];
    int unsigned run_mot, run_key, run_cnt;
    bit          fading;
    int unsigned tgt_mot, tgt_key, tgt_cnt, fade_pos, fade_len;
    int unsigned cfg_keys, cfg_parts;

    t_pose    pending_poses [$];
    t_req_row dir_rows [$];
    int       errors = 0;
    int       n_ticks = 0;
    int       n_poses = 0;
    int       n_items = 0;
    longint   cycles = 0;

    function automatic longint lerp64(longint a, longint b, int unsigned n, int unsigned d);
        return a + ((b - a) * longint'(n)) / longint'(d);
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic int unsigned dur_of(int unsigned m, int unsigned k);
        logic [11:0] f;
        f = key_durs[m * kpi_pkg::KEYS + k];
        return (f == 0) ? 1 : f;
    endfunction

    function automatic longint key_at(int unsigned m, int unsigned k, int unsigned p,
                                      int unsigned c);
        logic [31:0] u;
        u = key_vals[((m * kpi_pkg::KEYS + k) * kpi_pkg::PARTS + p) * kpi_pkg::CHANNELS + c];
        return (c < kpi_pkg::POS_CH) ? longint'($signed(u)) : longint'($signed(u[15:0]));
    endfunction

    function automatic longint chan_of(int unsigned m, int unsigned k, int unsigned cnt,
                                       int unsigned nk, int unsigned p, int unsigned c);
        longint v;
        v = lerp64(key_at(m, k, p, c), key_at(m, (k + 1) % nk, p, c), cnt, dur_of(m, k));
        return (c < kpi_pkg::POS_CH) ? clip32(v) : v;
    endfunction

    function automatic void reset_model();
        foreach (offsets[i]) offsets[i] = '0;
        foreach (key_durs[i]) key_durs[i] = 12'd1;
        run_mot = 0; run_key = 0; run_cnt = 0;
        fading = 0;
        tgt_mot = 0; tgt_key = 0; tgt_cnt = 0;
        fade_pos = 0; fade_len = 1;
        cfg_keys = 2; cfg_parts = 2;
    endfunction

    // Apply one accepted beat to the model and queue the poses it causes
    function automatic void pose_step(t_req_row r);
        int unsigned nk, np;
        longint v, w, s;
        t_pose pr;
        case (r.req)
            kpi_pkg::REQ_KEY_VAL: begin
                if (r.ch < kpi_pkg::CHANNELS)
                    key_vals[((r.mot * kpi_pkg::KEYS + r.key) * kpi_pkg::PARTS + r.part)
                             * kpi_pkg::CHANNELS + r.ch] = r.val;
                return;
            end
            kpi_pkg::REQ_KEY_FRM: begin
                key_durs[r.mot * kpi_pkg::KEYS + r.key] = r.fc;
                return;
            end
            kpi_pkg::REQ_OFFSET: begin
                if (r.ch < kpi_pkg::CHANNELS) offsets[r.part * kpi_pkg::CHANNELS + r.ch] = r.val;
                return;
            end
            kpi_pkg::REQ_START: begin
                if (r.bl) begin
                    fading = 1; fade_len = (r.fc == 0) ? 1 : r.fc; fade_pos = 0;
                    tgt_mot = r.mot; tgt_key = 0; tgt_cnt = 0;
                end else begin
                    run_mot = r.mot; run_key = 0; run_cnt = 0;
                end
                return;
            end
            kpi_pkg::REQ_TICK: ;
            default: return;
        endcase
        nk = (cfg_keys < 1) ? 1 : (cfg_keys > kpi_pkg::KEYS) ? kpi_pkg::KEYS : cfg_keys;
        np = (cfg_parts < 1) ? 1 : (cfg_parts > kpi_pkg::NP_MAX) ? kpi_pkg::NP_MAX : cfg_parts;
        n_ticks++;
        for (int unsigned i = 0; i < np; i++) begin
            pr.part = i[3:0];
            for (int unsigned c = 0; c < kpi_pkg::CHANNELS; c++) begin
                v = chan_of(run_mot, run_key, run_cnt, nk, i, c);
                if (fading) begin
                    w = chan_of(tgt_mot, tgt_key, tgt_cnt, nk, i, c);
                    v = lerp64(v, w, fade_pos, fade_len);
                end
                if (c < kpi_pkg::POS_CH)
                    s = clip32(v + longint'($signed(offsets[i * kpi_pkg::CHANNELS + c])));
                else
                    s = v + longint'($signed(offsets[i * kpi_pkg::CHANNELS + c][15:0]));
                case (c)
                    0: pr.px = s[31:0];
                    1: pr.py = s[31:0];
                    2: pr.pz = s[31:0];
                    3: pr.ax = s[15:0];
                    4: pr.ay = s[15:0];
                    default: pr.az = s[15:0];
                endcase
            end
            pr.last = (i + 1 == np);
            if (i == 0 && r.typ_px) pr.px = r.px;
            if (i == 0 && r.typ_ax) pr.ax = r.ax;
            pending_poses.push_back(pr);
        end
        // Advance the counters
        if (fading) begin
            tgt_cnt = (tgt_cnt + 1) & 12'hFFF;
            if (tgt_cnt >= dur_of(tgt_mot, tgt_key)) begin
                tgt_cnt = 0; tgt_key = (tgt_key + 1) % nk;
            end
            fade_pos = (fade_pos + 1) & 12'hFFF;
            if (fade_pos >= fade_len) begin
                fade_pos = 0; run_mot = tgt_mot; run_cnt = tgt_cnt; run_key = tgt_key;
                fading = 0;
            end
        end else begin
            run_cnt = (run_cnt + 1) & 12'hFFF;
            if (run_cnt >= dur_of(run_mot, run_key)) begin
                run_cnt = 0; run_key = (run_key + 1) % nk;
            end
        end
    endfunction

    function automatic t_req_row mk(logic [2:0] req, logic [2:0] m, logic [2:0] k,
                                    logic [3:0] p, logic [2:0] c, logic [31:0] v,
                                    logic [11:0] f, logic b);
        t_req_row r;
        r = '{req: req, mot: m, key: k, part: p, ch: c, val: v, fc: f, bl: b,
              typ_px: 1'b0, px: '0, typ_ax: 1'b0, ax: '0};
        return r;
    endfunction

    // Drive one beat and hold it until accepted
    task automatic send(t_req_row r);
        @(negedge i_clk);
        i_req_type = r.req; i_motion_index = r.mot; i_key_index = r.key;
        i_part_index = r.part; i_channel_index = r.ch; i_channel_value = r.val;
        i_frame_count = r.fc; i_blend_start = r.bl;
        start = 1'b1;
        do @(posedge i_clk); while (busy);
        pose_step(r);
        n_items++;
    endtask

    task automatic pause(int n);
        @(negedge i_clk);
        start = 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // Wait until every pose has arrived and the block has settled
    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_poses.size() != 0 || busy) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [0:0] idx, logic [4:0] data);
        @(negedge i_clk);
        i_cfg_we = 1'b1; i_cfg_idx = idx; i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == kpi_pkg::CFG_KEYS) cfg_keys = data[3:0];
        else cfg_parts = data;
    endtask

    // Check every pose beat against the oldest expectation
    always @(posedge i_clk) begin
        t_pose e;
        if (i_rst_n && o_valid) begin
            if (pending_poses.size() == 0) begin
                $display("%0t: unexpected pose beat part %0d", $time, o_part_number);
                errors++;
            end else begin
                e = pending_poses.pop_front();
                n_poses++;
                if (e.part !== o_part_number || e.px !== o_pos_x || e.py !== o_pos_y ||
                    e.pz !== o_pos_z || e.ax !== o_angle_x || e.ay !== o_angle_y ||
                    e.az !== o_angle_z || e.last !== o_last_part) begin
                    $display("%0t: expected part %0d pos %h %h %h ang %h %h %h last %b",
                             $time, e.part, e.px, e.py, e.pz, e.ax, e.ay, e.az, e.last);
                    $display("%0t:   actual part %0d pos %h %h %h ang %h %h %h last %b",
                             $time, o_part_number, o_pos_x, o_pos_y, o_pos_z,
                             o_angle_x, o_angle_y, o_angle_z, o_last_part);
                    errors++;
                end
            end
        end
    end

    // Run watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("keyframe_pose_interpolator: mismatch");
            $finish;
        end
    end

    initial begin
        t_req_row r;
        int sel, burst;
        reset_model();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Fill motions 0 and 1, keys 0 and 1, parts 0 and 1: all that any tick reads
        for (int m = 0; m < 2; m++)
            for (int k = 0; k < 2; k++) begin
                send(mk(kpi_pkg::REQ_KEY_FRM, 3'(m), 3'(k), 4'd0, 3'd0, 32'd0,
                        12'($urandom_range(1, 6)), 1'b0));
                for (int p = 0; p < 2; p++)
                    for (int c = 0; c < kpi_pkg::CHANNELS; c++)
                        send(mk(kpi_pkg::REQ_KEY_VAL, 3'(m), 3'(k), 4'(p), 3'(c),
                                32'($urandom), 12'd0, 1'b0));
            end

        // Directed rows: saturation, wrap, ignored requests, fades
        dir_rows.push_back(mk(kpi_pkg::REQ_START, 3'd0, 3'd0, 4'd0, 3'd0, 32'd0, 12'd0, 1'b0));
        dir_rows.push_back(mk(kpi_pkg::REQ_KEY_VAL, 3'd0, 3'd0, 4'd0, 3'd0, 32'h7FFF_FFFF,
                              12'd0, 1'b0));
        dir_rows.push_back(mk(kpi_pkg::REQ_OFFSET, 3'd0, 3'd0, 4'd0, 3'd0, 32'h7FFF_FFFF,
                              12'd0, 1'b0));
        r = mk(kpi_pkg::REQ_TICK, 3'd0, 3'd0, 4'd0, 3'd0, 32'd0, 12'd0, 1'b0);
        r.typ_px = 1'b1; r.px = 32'h7FFF_FFFF;
        dir_rows.push_back(r);
        dir_rows.push_back(mk(kpi_pkg::REQ_KEY_VAL, 3'd0, 3'd0, 4'd0, 3'd0, 32'h8000_0000,
                              12'd0, 1'b0));
        dir_rows.push_back(mk(kpi_pkg::REQ_OFFSET, 3'd0, 3'd0, 4'd0, 3'd0, 32'h8000_0000,
                              12'd0, 1'b0));
        dir_rows.push_back(mk(kpi_pkg::REQ_KEY_VAL, 3'd0, 3'd0, 4'd0, 3'd3, 32'h0000_7FFF,
                              12'd0, 1'b0));
        dir_rows.push_back(mk(kpi_pkg::REQ_OFFSET, 3'd0, 3'd0, 4'd0, 3'd3, 32'h0000_0001,
                              12'd0, 1'b0));
        dir_rows.push_back(mk(kpi_pkg::REQ_START, 3'd0, 3'd0, 4'd0, 3'd0, 32'd0, 12'd0, 1'b0));
        r = mk(kpi_pkg::REQ_TICK, 3'd0, 3'd0, 4'd0, 3'd0, 32'd0, 12'd0, 1'b0);
        r.typ_px = 1'b1; r.px = 32'h8000_0000;
        r.typ_ax = 1'b1; r.ax = 16'h8000;
        dir_rows.push_back(r);
        dir_rows.push_back(mk(3'd5, 3'd7, 3'd7, 4'd15, 3'd5, 32'hFFFF_FFFF, 12'hFFF, 1'b1));
        dir_rows.push_back(mk(3'd7, 3'd0, 3'd0, 4'd0, 3'd0, 32'd0, 12'd0, 1'b0));
        dir_rows.push_back(mk(kpi_pkg::REQ_KEY_VAL, 3'd1, 3'd1, 4'd1, 3'd6, 32'h1234_5678,
                              12'd0, 1'b0));
        dir_rows.push_back(mk(kpi_pkg::REQ_OFFSET, 3'd0, 3'd0, 4'd1, 3'd7, 32'hFFFF_FFFF,
                              12'd0, 1'b0));
        dir_rows.push_back(mk(kpi_pkg::REQ_KEY_FRM, 3'd1, 3'd0, 4'd0, 3'd0, 32'd0, 12'd0, 1'b0));
        dir_rows.push_back(mk(kpi_pkg::REQ_KEY_FRM, 3'd0, 3'd1, 4'd0, 3'd0, 32'd0, 12'hFFF,
                              1'b0));
        dir_rows.push_back(mk(kpi_pkg::REQ_START, 3'd1, 3'd0, 4'd0, 3'd0, 32'd0, 12'd0, 1'b1));
        dir_rows.push_back(mk(kpi_pkg::REQ_TICK, 3'd0, 3'd0, 4'd0, 3'd0, 32'd0, 12'd0, 1'b0));
        dir_rows.push_back(mk(kpi_pkg::REQ_START, 3'd1, 3'd0, 4'd0, 3'd0, 32'd0, 12'd4, 1'b1));
        dir_rows.push_back(mk(kpi_pkg::REQ_START, 3'd0, 3'd0, 4'd0, 3'd0, 32'd0, 12'd0, 1'b0));
        dir_rows.push_back(mk(kpi_pkg::REQ_TICK, 3'd0, 3'd0, 4'd0, 3'd0, 32'd0, 12'd0, 1'b0));
        dir_rows.push_back(mk(kpi_pkg::REQ_START, 3'd1, 3'd0, 4'd0, 3'd0, 32'd0, 12'd3, 1'b1));
        dir_rows.push_back(mk(kpi_pkg::REQ_TICK, 3'd0, 3'd0, 4'd0, 3'd0, 32'd0, 12'd0, 1'b0));
        dir_rows.push_back(mk(kpi_pkg::REQ_TICK, 3'd0, 3'd0, 4'd0, 3'd0, 32'd0, 12'd0, 1'b0));
        dir_rows.push_back(mk(kpi_pkg::REQ_KEY_FRM, 3'd0, 3'd0, 4'd0, 3'd0, 32'd0, 12'd1, 1'b0));
        dir_rows.push_back(mk(kpi_pkg::REQ_TICK, 3'd0, 3'd0, 4'd0, 3'd0, 32'd0, 12'd0, 1'b0));
        dir_rows.push_back(mk(kpi_pkg::REQ_TICK, 3'd0, 3'd0, 4'd0, 3'd0, 32'd0, 12'd0, 1'b0));
        foreach (dir_rows[i]) send(dir_rows[i]);

        // Random phases, each under its own register setting
        for (int ph = 0; ph < 4; ph++) begin
            drain();
            case (ph)
                0: begin
                    cfg_write(kpi_pkg::CFG_KEYS, 5'd0);
                    cfg_write(kpi_pkg::CFG_PARTS, 5'd0);
                end
                1: begin
                    cfg_write(kpi_pkg::CFG_KEYS, 5'd2);
                    cfg_write(kpi_pkg::CFG_PARTS, 5'd2);
                end
                2: begin
                    cfg_write(kpi_pkg::CFG_KEYS, 5'd1);
                    cfg_write(kpi_pkg::CFG_PARTS, 5'd1);
                end
                default: begin
                    cfg_write(kpi_pkg::CFG_KEYS, 5'h10 | 5'($urandom_range(0, 2)));
                    cfg_write(kpi_pkg::CFG_PARTS, 5'($urandom_range(0, 2)));
                end
            endcase
            burst = $urandom_range(1, 6);
            for (int n = 0; n < 7; n++) begin
                sel = $urandom_range(0, 99);
                r = mk(kpi_pkg::REQ_TICK, 3'($urandom), 3'($urandom), 4'($urandom),
                       3'($urandom_range(0, 7)), 32'($urandom), 12'($urandom_range(1, 8)),
                       1'($urandom));
                if ($urandom_range(0, 9) == 0) r.val = {$urandom_range(0, 1) ? 1'b0 : 1'b1,
                                                        {31{$urandom_range(0, 1) ? 1'b1 : 1'b0}}};
                if ($urandom_range(0, 9) == 0) r.fc = $urandom_range(0, 1) ? 12'd0 : 12'hFFF;
                if (sel < 40) r.req = kpi_pkg::REQ_TICK;
                else if (sel < 62) r.req = kpi_pkg::REQ_KEY_VAL;
                else if (sel < 72) r.req = kpi_pkg::REQ_OFFSET;
                else if (sel < 82) r.req = kpi_pkg::REQ_KEY_FRM;
                else if (sel < 95) begin
                    r.req = kpi_pkg::REQ_START;
                    r.mot = 3'($urandom_range(0, 1));
                end
                else r.req = 3'($urandom_range(5, 7));
                send(r);
                burst--;
                if (burst == 0) begin
                    pause($urandom_range(0, 5));
                    burst = $urandom_range(1, 6);
                end
            end
        end

        drain();
        $display("Ran %0d beats with %0d ticks; %0d poses checked over four register settings.",
                 n_items, n_ticks, n_poses);
        if (errors == 0) begin
            $display("keyframe_pose_interpolator: match");
        end else begin
            $display("keyframe_pose_interpolator: mismatch");
        end
        $finish;
    end

endmodule
